### hw/rtl/arxh_pkg.sv
// Shared types and constants of the ARX block hash: word and chain types,
// the initial vector, round count, rotation amounts and the control structs.
// No dependencies.
`default_nettype none

package arxh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t state_t [16];

  localparam int DOUBLE_ROUNDS = 5;
  localparam int ROUND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  localparam int ROT_0 = 17;
  localparam int ROT_1 = 13;
  localparam int ROT_2 = 9;
  localparam int ROT_3 = 5;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t INIT_VEC [16] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19,
    32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
    32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
  };

  typedef struct packed {
    logic start;
    logic load_iv;
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/arx_block_hash_256.sv
// Top level of the ARX block hash: byte packing, padding and length
// sequencer, digest output. Depends on arxh_pkg and arxh_compress.
//
// Channel  Direction  Payload                                   Handshake
// in       input      data_byte[8], byte_valid, last_byte       in_valid/in_ready
// out      output     digest_word[32], word_index[3], last_word out_valid/out_ready
//
// A message byte is taken whenever in_ready is high; every 64th byte adds one
// compression, run step by step on the single quarter round step unit.
// A last item adds padding at one byte per cycle up to the block end, eight length
// bytes, one or two compressions (56 zero bytes before the second), and eight
// output words. in_ready is low meanwhile.
// Reset is synchronous, active low, and loads the initial vector.
// Output stalls hold the digest word; no input is taken until word 7 leaves.
`default_nettype none

module arx_block_hash_256 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import arxh_pkg::*;

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_ABS  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_XTRA = 3'd3;
  localparam logic [2:0] S_ZERO = 3'd4;
  localparam logic [2:0] S_LEN  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] msg_r, msg_nxt;
  logic        last_pend_r, last_pend_nxt;
  logic        extra_r, extra_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        start_r, start_nxt;
  logic [2:0]  out_cnt_r, out_cnt_nxt;
  state_t      buf_r;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [63:0] len_bits;
  logic [5:0]  len_sel;
  logic [5:0]  fill_inc;
  cmp_ctrl_t   cmp_ctrl;
  cmp_stat_t   cmp_stat;
  state_t      chain;

  arxh_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cmp_ctrl),
    .block (buf_r),
    .stat  (cmp_stat),
    .chain (chain)
  );

  assign len_bits = {msg_r[60:0], 3'b000};
  assign len_sel  = {3'd7 - fill_r[2:0], 3'b000};
  assign fill_inc = fill_r + 6'd1;

  assign in_ready = (state_r == S_IN);

  assign cmp_ctrl.start   = start_r;
  assign cmp_ctrl.load_iv = (state_r == S_OUT) && out_ready && (out_cnt_r == 3'd7);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    last_pend_nxt = last_pend_r;
    extra_nxt     = extra_r;
    pad_first_nxt = pad_first_r;
    start_nxt     = 1'b0;
    out_cnt_nxt   = out_cnt_r;
    wr_en         = 1'b0;
    wr_byte       = in_data_byte;
    case (state_r)
      S_IN: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            wr_en    = 1'b1;
            msg_nxt  = msg_r + 64'd1;
            fill_nxt = fill_inc;
            if (fill_r == 6'd63) begin
              start_nxt     = 1'b1;
              last_pend_nxt = in_last_byte;
              state_nxt     = S_ABS;
            end else if (in_last_byte) begin
              pad_first_nxt = 1'b1;
              extra_nxt     = (fill_inc >= 6'd56);
              state_nxt     = S_PAD;
            end
          end else if (in_last_byte) begin
            pad_first_nxt = 1'b1;
            extra_nxt     = (fill_r >= 6'd56);
            state_nxt     = S_PAD;
          end
        end
      end
      S_ABS: begin
        if (cmp_stat.done) begin
          if (last_pend_r) begin
            pad_first_nxt = 1'b1;
            extra_nxt     = 1'b0;
            state_nxt     = S_PAD;
          end else begin
            state_nxt = S_IN;
          end
        end
      end
      S_PAD: begin
        wr_en         = 1'b1;
        wr_byte       = pad_first_r ? PAD_BYTE : 8'h00;
        pad_first_nxt = 1'b0;
        fill_nxt      = fill_inc;
        if (fill_r == 6'd63) begin
          if (extra_r) begin
            start_nxt = 1'b1;
            state_nxt = S_XTRA;
          end else begin
            fill_nxt  = 6'd56;
            state_nxt = S_LEN;
          end
        end
      end
      S_XTRA: begin
        if (cmp_stat.done) begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        wr_en    = 1'b1;
        wr_byte  = 8'h00;
        fill_nxt = fill_inc;
        if (fill_r == 6'd55) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        wr_en    = 1'b1;
        wr_byte  = len_bits[len_sel +: 8];
        fill_nxt = fill_inc;
        if (fill_r == 6'd63) begin
          start_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (cmp_stat.done) begin
          out_cnt_nxt = 3'd0;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_cnt_nxt = out_cnt_r + 3'd1;
          if (out_cnt_r == 3'd7) begin
            msg_nxt   = '0;
            fill_nxt  = '0;
            state_nxt = S_IN;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      fill_r      <= '0;
      msg_r       <= '0;
      last_pend_r <= 1'b0;
      extra_r     <= 1'b0;
      pad_first_r <= 1'b0;
      start_r     <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      last_pend_r <= last_pend_nxt;
      extra_r     <= extra_nxt;
      pad_first_r <= pad_first_nxt;
      start_r     <= start_nxt;
      out_cnt_r   <= out_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[fill_r[5:2]][{2'd3 - fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = chain[{1'b0, out_cnt_r}];
  assign out_word_index  = out_cnt_r;
  assign out_last_word   = (out_cnt_r == 3'd7);

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid && !cmp_stat.busy)
    else $error("input ready while output or compression active");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !cmp_stat.busy)
    else $error("compression started while compressor busy");

  a_done_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> in_ready && fill_r == 6'd0)
    else $error("block not returned to input after final digest word");

  a_start_at_full: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> fill_r == 6'd0)
    else $error("compression started on a partial block");
`endif

endmodule

`default_nettype wire

### hw/rtl/arxh_qr_step.sv
// One step of the quarter round: one add, one xor and one fixed rotation.
// Depends on arxh_pkg.
`default_nettype none

module arxh_qr_step (
  input  arxh_pkg::word_t a_in,
  input  arxh_pkg::word_t b_in,
  input  arxh_pkg::word_t c_in,
  input  arxh_pkg::word_t d_in,
  input  logic [1:0]      step,
  output arxh_pkg::word_t a_out,
  output arxh_pkg::word_t b_out,
  output arxh_pkg::word_t c_out,
  output arxh_pkg::word_t d_out
);
  import arxh_pkg::*;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  word_t sum;
  word_t mixed;
  word_t rotated;

  assign sum   = step[0] ? (c_in + d_in) : (a_in + b_in);
  assign mixed = step[0] ? (b_in ^ sum) : (d_in ^ sum);

  always_comb begin
    case (step)
      2'd0:    rotated = rotr(mixed, ROT_0);
      2'd1:    rotated = rotr(mixed, ROT_1);
      2'd2:    rotated = rotr(mixed, ROT_2);
      default: rotated = rotr(mixed, ROT_3);
    endcase
  end

  assign a_out = step[0] ? a_in : sum;
  assign d_out = step[0] ? d_in : rotated;
  assign c_out = step[0] ? sum : c_in;
  assign b_out = step[0] ? rotated : b_in;

endmodule

`default_nettype wire

### hw/rtl/arxh_compress.sv
// Block compressor: holds the chain and runs the double rounds one quarter
// round step per cycle on column 0, permuting the rows between quarter rounds.
// Depends on arxh_pkg and arxh_qr_step.
`default_nettype none

module arxh_compress (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arxh_pkg::cmp_ctrl_t   ctrl,
  input  arxh_pkg::state_t      block,
  output arxh_pkg::cmp_stat_t   stat,
  output arxh_pkg::state_t      chain
);
  import arxh_pkg::*;

  localparam logic [1:0] C_IDLE   = 2'd0;
  localparam logic [1:0] C_ROUND  = 2'd1;
  localparam logic [1:0] C_FINISH = 2'd2;

  function automatic state_t shift_rows(input state_t v);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shift_rows[4 * r + c] = v[4 * r + ((c + 1) % 4)];
      end
    end
  endfunction

  function automatic state_t diag_rows(input state_t v);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        diag_rows[4 * r + c] = v[4 * r + ((c + r) % 4)];
      end
    end
  endfunction

  function automatic state_t undiag_rows(input state_t v);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        undiag_rows[4 * r + c] = v[4 * r + ((c - r + 4) % 4)];
      end
    end
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               half_r, half_nxt;
  logic [1:0]         qr_r, qr_nxt;
  logic [1:0]         step_r, step_nxt;
  logic               done_r, done_nxt;
  state_t             v_r, v_nxt;
  state_t             saved_r;
  state_t             stepped;
  state_t             shifted;
  word_t              qa, qb, qc, qd;
  logic               last_step;

  arxh_qr_step u_step (
    .a_in  (v_r[0]),
    .b_in  (v_r[4]),
    .c_in  (v_r[8]),
    .d_in  (v_r[12]),
    .step  (step_r),
    .a_out (qa),
    .b_out (qb),
    .c_out (qc),
    .d_out (qd)
  );

  assign last_step = (round_r == ROUND_W'(DOUBLE_ROUNDS - 1)) && half_r &&
                     (qr_r == 2'd3) && (step_r == 2'd3);

  always_comb begin
    stepped     = v_r;
    stepped[0]  = qa;
    stepped[4]  = qb;
    stepped[8]  = qc;
    stepped[12] = qd;
    shifted     = shift_rows(stepped);
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    half_nxt  = half_r;
    qr_nxt    = qr_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    v_nxt     = v_r;
    case (state_r)
      C_IDLE: begin
        if (ctrl.start) begin
          for (int i = 0; i < 16; i++) begin
            v_nxt[i] = v_r[i] ^ block[i];
          end
          state_nxt = C_ROUND;
          round_nxt = '0;
          half_nxt  = 1'b0;
          qr_nxt    = 2'd0;
          step_nxt  = 2'd0;
        end else if (ctrl.load_iv) begin
          v_nxt = INIT_VEC;
        end
      end
      C_ROUND: begin
        step_nxt = step_r + 2'd1;
        if (step_r != 2'd3) begin
          v_nxt = stepped;
        end else begin
          qr_nxt = qr_r + 2'd1;
          if (qr_r != 2'd3) begin
            v_nxt = shifted;
          end else if (!half_r) begin
            v_nxt    = diag_rows(shifted);
            half_nxt = 1'b1;
          end else begin
            v_nxt     = undiag_rows(shifted);
            half_nxt  = 1'b0;
            round_nxt = round_r + ROUND_W'(1);
          end
        end
        if (last_step) begin
          state_nxt = C_FINISH;
        end
      end
      C_FINISH: begin
        for (int i = 0; i < 16; i++) begin
          v_nxt[i] = v_r[i] ^ saved_r[i];
        end
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      round_r <= '0;
      half_r  <= 1'b0;
      qr_r    <= 2'd0;
      step_r  <= 2'd0;
      done_r  <= 1'b0;
      v_r     <= INIT_VEC;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      half_r  <= half_nxt;
      qr_r    <= qr_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
      v_r     <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && ctrl.start) begin
      saved_r <= v_r;
    end
  end

  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = done_r;
  assign chain     = v_r;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for arx_block_hash_256: drives message bytes, predicts
// every digest word with a behavioral hash model and checks the result channel.
// Depends on arxh_pkg for the initial vector, round count and rotation amounts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arxh_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {RDY_FULL, RDY_RANDOM, RDY_SLOW} rdy_mode_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  word_t       hash_chain [16];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [63:0] msg_len;

  digest_exp_t digest_q [$];
  digest_exp_t got_exp;
  int          errors = 0;
  int          items_sent = 0;
  int          items_total = 0;
  int          msgs_done = 0;
  int          words_checked = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  rdy_mode_t   rdy_mode = RDY_FULL;
  int          rdy_count = 0;

  arx_block_hash_256 u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_valid   (in_byte_valid),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void mix_quarter(int a, int b, int c, int d);
    hash_chain[a] += hash_chain[b];
    hash_chain[d] = rotr(hash_chain[d] ^ hash_chain[a], ROT_0);
    hash_chain[c] += hash_chain[d];
    hash_chain[b] = rotr(hash_chain[b] ^ hash_chain[c], ROT_1);
    hash_chain[a] += hash_chain[b];
    hash_chain[d] = rotr(hash_chain[d] ^ hash_chain[a], ROT_2);
    hash_chain[c] += hash_chain[d];
    hash_chain[b] = rotr(hash_chain[b] ^ hash_chain[c], ROT_3);
  endfunction

  function automatic void compress_block();
    word_t saved [16];
    saved = hash_chain;
    for (int i = 0; i < 16; i++) begin
      hash_chain[i] ^= {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      hash_chain[i] ^= saved[i];
    end
  endfunction

  function automatic void restart_hash();
    hash_chain = INIT_VEC;
    blk_fill = 0;
    msg_len = '0;
  endfunction

  function automatic void absorb_item(logic [7:0] b, logic bv, logic lst);
    logic [63:0] bit_len;
    digest_exp_t e;
    if (bv) begin
      blk_bytes[blk_fill] = b;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (!lst) return;
    blk_bytes[blk_fill] = PAD_BYTE;
    for (int i = blk_fill + 1; i < 64; i++) blk_bytes[i] = 8'h00;
    if (blk_fill >= 56) begin
      compress_block();
      for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    end
    bit_len = msg_len << 3;
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      e.word = hash_chain[i];
      e.idx = 3'(i);
      e.last = (i == 7);
      digest_q.push_back(e);
    end
    restart_hash();
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest word %h index %0d arrived with none expected",
                 $time, out_digest_word, out_word_index);
        errors++;
      end else begin
        got_exp = digest_q.pop_front();
        words_checked++;
        if (out_digest_word !== got_exp.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, got_exp.word,
                   out_digest_word);
          errors++;
        end
        if (out_word_index !== got_exp.idx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, got_exp.idx,
                   out_word_index);
          errors++;
        end
        if (out_last_word !== got_exp.last) begin
          $display("%0t: last_word expected %b actual %b", $time, got_exp.last,
                   out_last_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d digest words outstanding", $time,
               STALL_LIMIT, digest_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rdy_count == 0) begin
      rdy_mode <= rdy_mode_t'(2'($urandom_range(0, 2)));
      rdy_count <= $urandom_range(20, 80);
    end else begin
      rdy_count <= rdy_count - 1;
    end
    case (rdy_mode)
      RDY_FULL: begin
        out_ready <= 1'b1;
      end
      RDY_RANDOM: begin
        out_ready <= ($urandom_range(0, 99) < 60);
      end
      default: begin
        out_ready <= (rdy_count % 5 == 0);
      end
    endcase
  end

  task automatic send_item(input logic [7:0] b, input logic bv, input logic lst);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_byte_valid <= bv;
    in_last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_item(b, bv, lst);
    items_total++;
    if (bv) items_sent++;
    if (lst) msgs_done++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_message(input int len, input bit bare_end, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (len == 0 || bare_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_idle_items();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
  endtask

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_single_bytes();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_bit_patterns();
    for (int i = 0; i < 8; i++) send_item(8'h01 << i, 1'b1, i == 7);
  endtask

  // Lengths cluster at short messages, around the padding edges, where the length field spills
  // into an extra block, and around whole blocks.
  task automatic test_random_messages(input int target);
    int len;
    int pick;
    while (items_total < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(0, 8);
      else if (pick < 85) len = $urandom_range(52, 68);
      else if (pick < 90) len = $urandom_range(118, 130);
      else len = $urandom_range(9, 51);
      if (len > target - items_total) len = target - items_total;
      send_message(len, $urandom_range(0, 1), 1'b1);
    end
  endtask

  task automatic test_drain_pause();
    send_message(3, 1'b0, 1'b0);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat ($urandom_range(5, 30)) @(negedge clk);
  endtask

  initial begin
    restart_hash();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_items();
    test_empty_message();
    test_single_bytes();
    test_bit_patterns();
    test_random_messages(160);
    test_drain_pause();
    test_random_messages(310);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Hashed %0d messages from %0d items, %0d of them message bytes.",
             msgs_done, items_total, items_sent);
    $display("Checked %0d digest words, %0d mismatches.", words_checked, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
